// File: hdl/ale_pkg.sv
// Shared types, constants and the microcode ROM for the array list engine.
package ale_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned ACT_W        = 3;
  localparam int unsigned POS_W        = 7;
  localparam int unsigned STAT_W       = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT      = 3'd0,
    ACT_DELETE      = 3'd1,
    ACT_UPDATE      = 3'd2,
    ACT_APPEND      = 3'd3,
    ACT_REMOVE_LAST = 3'd4,
    ACT_LOCATE      = 3'd5,
    ACT_GET         = 3'd6,
    ACT_CLEAR       = 3'd7
  } act_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // Microprogram addresses.
  typedef enum logic [4:0] {
    S_IDLE, S_INS_CHK, S_INS_FULL, S_INS_LOOP, S_INS_WR,
    S_DEL_CHK, S_DEL_CAP, S_DEL_LOOP, S_DEL_END,
    S_UPD_CHK, S_UPD_WR, S_APP_CHK, S_APP_WR,
    S_RML_CHK, S_RML_RD, S_RML_CAP, S_GET_CHK, S_GET_CAP,
    S_CLR, S_LOC_INIT, S_LOC_LOOP, S_DONE
  } step_t;

  typedef enum logic [3:0] {
    BR_NEVER, BR_ALWAYS, BR_NO_IN, BR_INS_BAD, BR_ACC_BAD, BR_FULL,
    BR_EMPTY, BR_WALK_DN, BR_WALK_UP, BR_LOC_MORE, BR_OUT_BUSY
  } cond_t;

  typedef enum logic [2:0] {
    M_NONE, M_RD_POS, M_RD_LAST, M_WR_POS, M_WR_TAIL,
    M_SHIFT_UP, M_SHIFT_DN, M_PROBE
  } mem_op_t;

  typedef enum logic [2:0] {
    PT_HOLD, PT_CNT, PT_POS, PT_ZERO, PT_INC, PT_DEC
  } ptr_op_t;

  typedef enum logic [1:0] {
    CT_HOLD, CT_INC, CT_DEC, CT_ZERO
  } cnt_op_t;

  typedef struct packed {
    cond_t   cond;
    step_t   tgt;      // next step when the condition holds
    step_t   nxt;      // next step otherwise
    logic    disp;     // otherwise dispatch on the incoming action
    logic    take_in;
    logic    st_en;    // set status when the condition holds
    status_t st;
    mem_op_t mem;
    ptr_op_t ptr_op;
    cnt_op_t cnt_op;
    logic    vout_ld;
    logic    out_ld;
  } ucw_t;

  typedef struct packed {
    ucw_t cw;
    logic taken;
  } seq_ctl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic ins_bad;
    logic acc_bad;
    logic full;
    logic empty;
    logic walk_dn;
    logic walk_up;
    logic loc_more;
  } flags_t;

  localparam ucw_t UCW_NOP = '{
    cond: BR_NEVER, tgt: S_IDLE, nxt: S_IDLE, disp: 1'b0, take_in: 1'b0,
    st_en: 1'b0, st: ST_OK, mem: M_NONE, ptr_op: PT_HOLD, cnt_op: CT_HOLD,
    vout_ld: 1'b0, out_ld: 1'b0
  };

  function automatic step_t entry(act_t act);
    step_t s;
    case (act)
      ACT_INSERT:      s = S_INS_CHK;
      ACT_DELETE:      s = S_DEL_CHK;
      ACT_UPDATE:      s = S_UPD_CHK;
      ACT_APPEND:      s = S_APP_CHK;
      ACT_REMOVE_LAST: s = S_RML_CHK;
      ACT_LOCATE:      s = S_LOC_INIT;
      ACT_GET:         s = S_GET_CHK;
      ACT_CLEAR:       s = S_CLR;
      default:         s = S_CLR;
    endcase
    return s;
  endfunction

  // Control ROM: one word per step.
  function automatic ucw_t ucode(step_t s);
    ucw_t cw;
    cw = UCW_NOP;
    case (s)
      S_IDLE: begin
        cw.cond = BR_NO_IN; cw.tgt = S_IDLE; cw.disp = 1'b1; cw.take_in = 1'b1;
      end
      S_INS_CHK: begin
        cw.cond = BR_INS_BAD; cw.tgt = S_DONE; cw.st_en = 1'b1; cw.st = ST_BAD_POS;
        cw.nxt = S_INS_FULL;
      end
      S_INS_FULL: begin
        cw.cond = BR_FULL; cw.tgt = S_DONE; cw.st_en = 1'b1; cw.st = ST_FULL;
        cw.ptr_op = PT_CNT; cw.nxt = S_INS_LOOP;
      end
      S_INS_LOOP: begin
        cw.cond = BR_WALK_DN; cw.tgt = S_INS_LOOP; cw.mem = M_SHIFT_UP;
        cw.ptr_op = PT_DEC; cw.nxt = S_INS_WR;
      end
      S_INS_WR: begin
        cw.mem = M_WR_POS; cw.cnt_op = CT_INC; cw.nxt = S_DONE;
      end
      S_DEL_CHK: begin
        cw.cond = BR_ACC_BAD; cw.tgt = S_DONE; cw.st_en = 1'b1; cw.st = ST_BAD_POS;
        cw.mem = M_RD_POS; cw.ptr_op = PT_POS; cw.nxt = S_DEL_CAP;
      end
      S_DEL_CAP: begin
        cw.vout_ld = 1'b1; cw.nxt = S_DEL_LOOP;
      end
      S_DEL_LOOP: begin
        cw.cond = BR_WALK_UP; cw.tgt = S_DEL_LOOP; cw.mem = M_SHIFT_DN;
        cw.ptr_op = PT_INC; cw.nxt = S_DEL_END;
      end
      S_DEL_END: begin
        cw.cnt_op = CT_DEC; cw.nxt = S_DONE;
      end
      S_UPD_CHK: begin
        cw.cond = BR_ACC_BAD; cw.tgt = S_DONE; cw.st_en = 1'b1; cw.st = ST_BAD_POS;
        cw.nxt = S_UPD_WR;
      end
      S_UPD_WR: begin
        cw.mem = M_WR_POS; cw.nxt = S_DONE;
      end
      S_APP_CHK: begin
        cw.cond = BR_FULL; cw.tgt = S_DONE; cw.st_en = 1'b1; cw.st = ST_FULL;
        cw.nxt = S_APP_WR;
      end
      S_APP_WR: begin
        cw.mem = M_WR_TAIL; cw.cnt_op = CT_INC; cw.nxt = S_DONE;
      end
      S_RML_CHK: begin
        cw.cond = BR_EMPTY; cw.tgt = S_DONE; cw.st_en = 1'b1; cw.st = ST_EMPTY;
        cw.nxt = S_RML_RD;
      end
      S_RML_RD: begin
        cw.mem = M_RD_LAST; cw.cnt_op = CT_DEC; cw.nxt = S_RML_CAP;
      end
      S_RML_CAP: begin
        cw.vout_ld = 1'b1; cw.nxt = S_DONE;
      end
      S_GET_CHK: begin
        cw.cond = BR_ACC_BAD; cw.tgt = S_DONE; cw.st_en = 1'b1; cw.st = ST_BAD_POS;
        cw.mem = M_RD_POS; cw.nxt = S_GET_CAP;
      end
      S_GET_CAP: begin
        cw.vout_ld = 1'b1; cw.nxt = S_DONE;
      end
      S_CLR: begin
        cw.cnt_op = CT_ZERO; cw.nxt = S_DONE;
      end
      S_LOC_INIT: begin
        cw.cond = BR_ALWAYS; cw.tgt = S_LOC_LOOP; cw.st_en = 1'b1;
        cw.st = ST_NOT_FOUND; cw.ptr_op = PT_ZERO;
      end
      S_LOC_LOOP: begin
        cw.cond = BR_LOC_MORE; cw.tgt = S_LOC_LOOP; cw.mem = M_PROBE;
        cw.ptr_op = PT_INC; cw.nxt = S_DONE;
      end
      S_DONE: begin
        cw.cond = BR_OUT_BUSY; cw.tgt = S_DONE; cw.out_ld = 1'b1; cw.nxt = S_IDLE;
      end
      default: cw = UCW_NOP;
    endcase
    return cw;
  endfunction

endpackage

// File: hdl/ale_if.sv
// Command and response channel interfaces of the array list engine.
interface ale_cmd_if;
  logic                               valid;
  logic                               ready;
  logic [ale_pkg::ACT_W-1:0]          action;
  logic [ale_pkg::POS_W-1:0]          position;
  logic signed [ale_pkg::DATA_W-1:0]  value_in;

  modport source (output valid, action, position, value_in, input ready);
  modport sink   (input valid, action, position, value_in, output ready);
endinterface

interface ale_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [ale_pkg::STAT_W-1:0]         status;
  logic signed [ale_pkg::DATA_W-1:0]  value_out;
  logic [ale_pkg::POS_W-1:0]          found_position;
  logic [ale_pkg::POS_W-1:0]          count;

  modport source (output valid, status, value_out, found_position, count, input ready);
  modport sink   (input valid, status, value_out, found_position, count, output ready);
endinterface

// File: hdl/ale_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ale_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/ale_useq.sv
// Microsequencer: step counter, control ROM lookup and branch logic.
module ale_useq (
  input  logic              clk,
  input  logic              rst_n,
  input  ale_pkg::flags_t   flags,
  input  ale_pkg::act_t     in_act,
  output ale_pkg::seq_ctl_t ctl
);

  ale_pkg::step_t step_r;
  ale_pkg::step_t step_nxt;
  ale_pkg::ucw_t  cw;
  logic           taken;

  always_comb begin
    cw = ale_pkg::ucode(step_r);
  end

  always_comb begin
    case (cw.cond)
      ale_pkg::BR_NEVER:    taken = 1'b0;
      ale_pkg::BR_ALWAYS:   taken = 1'b1;
      ale_pkg::BR_NO_IN:    taken = !flags.in_valid;
      ale_pkg::BR_INS_BAD:  taken = flags.ins_bad;
      ale_pkg::BR_ACC_BAD:  taken = flags.acc_bad;
      ale_pkg::BR_FULL:     taken = flags.full;
      ale_pkg::BR_EMPTY:    taken = flags.empty;
      ale_pkg::BR_WALK_DN:  taken = flags.walk_dn;
      ale_pkg::BR_WALK_UP:  taken = flags.walk_up;
      ale_pkg::BR_LOC_MORE: taken = flags.loc_more;
      ale_pkg::BR_OUT_BUSY: taken = flags.out_busy;
      default:              taken = 1'b0;
    endcase
  end

  always_comb begin
    if (taken) begin
      step_nxt = cw.tgt;
    end else if (cw.disp) begin
      step_nxt = ale_pkg::entry(in_act);
    end else begin
      step_nxt = cw.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ale_pkg::S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign ctl.cw    = cw;
  assign ctl.taken = taken;

endmodule

// File: hdl/ale_dpath.sv
// Datapath: list length, walk pointer, entry memory and the result register.
module ale_dpath #(
  parameter int unsigned CAPACITY = ale_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ale_pkg::seq_ctl_t           ctl,
  input  logic                        in_valid,
  input  logic [ale_pkg::POS_W-1:0]   in_position,
  input  logic [ale_pkg::DATA_W-1:0]  in_value,
  input  logic                        out_ready,
  output ale_pkg::flags_t             flags,
  output logic                        out_valid,
  output ale_pkg::status_t            out_status,
  output logic [ale_pkg::DATA_W-1:0]  out_value,
  output logic [ale_pkg::POS_W-1:0]   out_found,
  output logic [ale_pkg::POS_W-1:0]   out_count
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W = ale_pkg::POS_W;
  localparam int unsigned DW    = ale_pkg::DATA_W;
  localparam int unsigned XW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [POS_W-1:0]  pos_r;
  logic [DW-1:0]     val_r;
  ale_pkg::status_t  status_r;
  logic [DW-1:0]     vout_r;
  logic [CNT_W-1:0]  found_r;
  logic              cpy_pend_r;
  logic [AW-1:0]     dst_r;
  logic              prb_pend_r;
  logic [CNT_W-1:0]  pidx_r;
  logic              out_valid_r;
  ale_pkg::status_t  out_status_r;
  logic [DW-1:0]     out_value_r;
  logic [POS_W-1:0]  out_found_r;
  logic [POS_W-1:0]  out_count_r;

  ale_pkg::ucw_t     cw;
  logic              accept;
  logic              fire;
  logic              hit_now;
  logic              walk_up;
  logic              out_busy;
  logic              out_load;
  logic              is_shift;
  logic              is_probe;
  logic [XW-1:0]     pos_x;
  logic [XW-1:0]     cnt_x;
  logic [XW-1:0]     pos_dec;
  logic [CNT_W-1:0]  ptr_dec;
  logic [CNT_W-1:0]  cnt_dec;
  logic [CNT_W-1:0]  ptr_inc;

  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [DW-1:0]     ram_rd_data;
  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [DW-1:0]     ram_wr_data;

  assign cw       = ctl.cw;
  assign accept   = cw.take_in && in_valid;
  assign pos_x    = XW'(pos_r);
  assign cnt_x    = XW'(cnt_r);
  assign pos_dec  = pos_x - XW'(1);
  assign ptr_dec  = ptr_r - CNT_W'(1);
  assign cnt_dec  = cnt_r - CNT_W'(1);
  assign ptr_inc  = ptr_r + CNT_W'(1);
  assign walk_up  = ptr_r < cnt_r;
  assign hit_now  = prb_pend_r && (ram_rd_data == val_r);
  assign out_busy = out_valid_r && !out_ready;
  assign out_load = cw.out_ld && !out_busy;
  assign is_shift = (cw.mem == ale_pkg::M_SHIFT_UP) || (cw.mem == ale_pkg::M_SHIFT_DN);
  assign is_probe = cw.mem == ale_pkg::M_PROBE;

  always_comb begin
    if (is_shift) begin
      fire = ctl.taken;
    end else if (is_probe) begin
      fire = walk_up && !hit_now;
    end else begin
      fire = 1'b1;
    end
  end

  assign flags.in_valid = in_valid;
  assign flags.out_busy = out_busy;
  assign flags.ins_bad  = (pos_x == '0) || (pos_x > cnt_x + XW'(1));
  assign flags.acc_bad  = (pos_x == '0) || (pos_x > cnt_x);
  assign flags.full     = cnt_r == CNT_W'(CAPACITY);
  assign flags.empty    = cnt_r == '0;
  assign flags.walk_dn  = XW'(ptr_r) >= pos_x;
  assign flags.walk_up  = walk_up;
  // keep walking until a match shows, or all probes are in and checked
  assign flags.loc_more = !hit_now && (walk_up || prb_pend_r);

  // Memory port steering; a pending shift copy owns the write port.
  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = ptr_r[AW-1:0];
    ram_wr_en   = cpy_pend_r;
    ram_wr_addr = dst_r;
    ram_wr_data = ram_rd_data;
    case (cw.mem)
      ale_pkg::M_RD_POS: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = pos_dec[AW-1:0];
      end
      ale_pkg::M_RD_LAST: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = cnt_dec[AW-1:0];
      end
      ale_pkg::M_WR_POS: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = pos_dec[AW-1:0];
        ram_wr_data = val_r;
      end
      ale_pkg::M_WR_TAIL: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = cnt_r[AW-1:0];
        ram_wr_data = val_r;
      end
      ale_pkg::M_SHIFT_UP: begin
        ram_rd_en   = fire;
        ram_rd_addr = ptr_dec[AW-1:0];
      end
      ale_pkg::M_SHIFT_DN: begin
        ram_rd_en   = fire;
        ram_rd_addr = ptr_r[AW-1:0];
      end
      ale_pkg::M_PROBE: begin
        ram_rd_en   = fire;
        ram_rd_addr = ptr_r[AW-1:0];
      end
      default: begin
        ram_rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (cw.ptr_op)
      ale_pkg::PT_CNT:  ptr_nxt = cnt_r;
      ale_pkg::PT_POS:  ptr_nxt = CNT_W'(pos_r);
      ale_pkg::PT_ZERO: ptr_nxt = '0;
      ale_pkg::PT_INC:  ptr_nxt = fire ? ptr_inc : ptr_r;
      ale_pkg::PT_DEC:  ptr_nxt = fire ? ptr_dec : ptr_r;
      default:          ptr_nxt = ptr_r;
    endcase
  end

  always_comb begin
    case (cw.cnt_op)
      ale_pkg::CT_INC:  cnt_nxt = cnt_r + CNT_W'(1);
      ale_pkg::CT_DEC:  cnt_nxt = cnt_dec;
      ale_pkg::CT_ZERO: cnt_nxt = '0;
      default:          cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      cpy_pend_r  <= 1'b0;
      prb_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      cpy_pend_r <= fire && is_shift;
      prb_pend_r <= fire && is_probe;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    // shift up writes one slot above the read, shift down one below
    dst_r  <= (cw.mem == ale_pkg::M_SHIFT_UP) ? ptr_r[AW-1:0] : ptr_dec[AW-1:0];
    pidx_r <= ptr_inc;
    if (accept) begin
      pos_r    <= in_position;
      val_r    <= in_value;
      status_r <= ale_pkg::ST_OK;
      vout_r   <= '0;
      found_r  <= '0;
    end else begin
      if (cw.st_en && ctl.taken) begin
        status_r <= cw.st;
      end else if (is_probe && hit_now) begin
        status_r <= ale_pkg::ST_OK;
      end
      if (is_probe && hit_now) begin
        found_r <= pidx_r;
      end
      if (cw.vout_ld) begin
        vout_r <= ram_rd_data;
      end
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_value_r  <= vout_r;
      out_found_r  <= POS_W'(found_r);
      out_count_r  <= POS_W'(cnt_r);
    end
  end

  ale_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_found  = out_found_r;
  assign out_count  = out_count_r;

endmodule

// File: hdl/array_list_engine.sv
// Array list engine top level: one command word in, one result word out.
// Commands run one at a time: a new command word is taken only in the idle step, after the
// result word of the last one is loaded; insert and delete walk the entries between the
// position and the end, locate walks until a match or the end of the list is reached.
// A stalled result word holds the input off.
// Reset (rst_n, synchronous) empties the list and idles the sequencer; entries keep their bits.
module array_list_engine #(
  parameter int unsigned CAPACITY = ale_pkg::CAPACITY_DEF
) (
  input logic         clk,
  input logic         rst_n,
  ale_cmd_if.sink     in_cmd,
  ale_rsp_if.source   out_rsp
);

  ale_pkg::seq_ctl_t ctl;
  ale_pkg::flags_t   flags;
  ale_pkg::status_t  rsp_status;

  ale_useq u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .flags  (flags),
    .in_act (ale_pkg::act_t'(in_cmd.action)),
    .ctl    (ctl)
  );

  ale_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .in_valid    (in_cmd.valid),
    .in_position (in_cmd.position),
    .in_value    (in_cmd.value_in),
    .out_ready   (out_rsp.ready),
    .flags       (flags),
    .out_valid   (out_rsp.valid),
    .out_status  (rsp_status),
    .out_value   (out_rsp.value_out),
    .out_found   (out_rsp.found_position),
    .out_count   (out_rsp.count)
  );

  assign in_cmd.ready   = ctl.cw.take_in;
  assign out_rsp.status = rsp_status;

endmodule
